/* sv/uv_duty_cycle_sampler_assert.svh */
// Assertion helpers shared by the sampler modules.
// Every macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef UV_DUTY_CYCLE_SAMPLER_ASSERT_SVH
`define UV_DUTY_CYCLE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVDS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UVDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/uvds_pkg.sv */
package uvds_pkg;

  localparam int PeriodW = 16;
  localparam int TimeW   = 32;
  localparam int RawW    = 16;
  localparam int IndexW  = 8;

  // Phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OFF   = 2'd1;
  localparam logic [1:0] PH_ON    = 2'd2;
  localparam logic [1:0] PH_READY = 2'd3;

  // Sensor command codes.
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_CONFIGURE = 2'd1;
  localparam logic [1:0] CMD_DISABLE   = 2'd2;

  // Item kinds.
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_MINUTE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam logic [PeriodW-1:0] FgPeriodReset = 16'd1;
  localparam logic [PeriodW-1:0] BgPeriodReset = 16'd100;

  // Doubled readings at or above 256*7 give an index past 255.
  localparam logic [RawW:0] IndexSatLimit = 17'd1792;
  // 9363 / 2^16 slightly exceeds 1/7; exact for all operands below 1792.
  localparam logic [13:0] IndexRecip = 14'd9363;

  typedef struct packed {
    logic              kind;
    logic [TimeW-1:0]  now_seconds;
    logic              asleep;
    logic              ui_idle;
    logic              viewing_uv;
    logic              measure_request;
    logic [RawW-1:0]   raw_uv;
  } item_t;

  typedef struct packed {
    logic [1:0]        sensor_command;
    logic [1:0]        phase_now;
    logic [IndexW-1:0] index_now;
    logic [IndexW-1:0] max_now;
    logic [IndexW-1:0] max_view_now;
    logic [IndexW-1:0] minute_max;
  } result_t;

endpackage

/* sv/uvds_index.sv */
module uvds_index (
  input  logic [uvds_pkg::RawW-1:0]   raw_uv,
  output logic [uvds_pkg::IndexW-1:0] index
);
  import uvds_pkg::*;

  logic [RawW:0] doubled;
  logic [23:0]   prod;

  assign doubled = {raw_uv, 1'b0};
  assign prod    = 24'({13'd0, doubled[10:0]}) * 24'(IndexRecip);

  always_comb begin
    if (doubled >= IndexSatLimit) begin
      index = 8'hFF;
    end else begin
      index = prod[23:16];
    end
  end

endmodule

/* sv/uvds_core.sv */
module uvds_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  uvds_pkg::item_t              item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [uvds_pkg::PeriodW-1:0] cfg_data,
  output uvds_pkg::result_t            res_next
);
  import uvds_pkg::*;

  logic [PeriodW-1:0] fg_period;
  logic [PeriodW-1:0] bg_period;

  logic [1:0]        phase, phase_next;
  logic [TimeW-1:0]  time_base, time_base_next;
  logic              pending, pending_next;
  logic [IndexW-1:0] cur_index, cur_index_next;
  logic [IndexW-1:0] run_max, run_max_next;
  logic [IndexW-1:0] view_max, view_max_next;
  logic [1:0]        cmd;
  logic [IndexW-1:0] minute;

  logic [IndexW-1:0] new_index;
  logic [TimeW-1:0]  diff;
  logic              viewing;

  uvds_index u_index (
    .raw_uv (item.raw_uv),
    .index  (new_index)
  );

  assign diff    = item.now_seconds - time_base;
  assign viewing = !item.ui_idle && item.viewing_uv;

  always_comb begin
    phase_next     = phase;
    time_base_next = time_base;
    pending_next   = pending;
    cur_index_next = cur_index;
    run_max_next   = run_max;
    view_max_next  = view_max;
    cmd            = CMD_NONE;
    minute         = '0;

    if (item.kind == KIND_MINUTE) begin
      minute       = run_max;
      run_max_next = cur_index;
    end else begin
      if (item.measure_request) begin
        pending_next = 1'b1;
      end
      if (item.asleep) begin
        phase_next = PH_IDLE;
      end else begin
        case (phase)
          PH_IDLE: begin
            phase_next = PH_OFF;
          end
          PH_ON: begin
            cmd        = CMD_CONFIGURE;
            phase_next = PH_READY;
          end
          PH_READY: begin
            cur_index_next = new_index;
            if (run_max < new_index) begin
              run_max_next = new_index;
            end
            // UI maximum: new index while idle, else running maximum on an index above it.
            if (item.ui_idle) begin
              view_max_next = new_index;
            end else if (new_index > view_max) begin
              view_max_next = run_max_next;
            end
            cmd        = CMD_DISABLE;
            phase_next = PH_OFF;
          end
          default: begin
            if (viewing) begin
              if (diff > {16'd0, fg_period}) begin
                phase_next = PH_ON;
              end
            end else if (diff > {16'd0, bg_period} && pending_next) begin
              pending_next   = 1'b0;
              time_base_next = item.now_seconds;
              phase_next     = PH_ON;
            end
          end
        endcase
      end
    end
  end

  assign res_next.sensor_command = cmd;
  assign res_next.phase_now      = phase_next;
  assign res_next.index_now      = cur_index_next;
  assign res_next.max_now        = run_max_next;
  assign res_next.max_view_now   = view_max_next;
  assign res_next.minute_max     = minute;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_period <= FgPeriodReset;
      bg_period <= BgPeriodReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FOREGROUND) begin
        fg_period <= cfg_data;
      end else begin
        bg_period <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      time_base <= '0;
      pending   <= 1'b0;
      cur_index <= '0;
      run_max   <= '0;
      view_max  <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      time_base <= time_base_next;
      pending   <= pending_next;
      cur_index <= cur_index_next;
      run_max   <= run_max_next;
      view_max  <= view_max_next;
    end
  end

  `include "uv_duty_cycle_sampler_assert.svh"

  `UVDS_ASSERT_IMPLY(a_max_covers_index, 1'b1, run_max >= cur_index,
                     "running max below index")
  `UVDS_ASSERT_NEXT(a_sleep_idles, fire && item.kind == KIND_TICK && item.asleep,
                    phase == PH_IDLE, "sleep tick did not idle")
  `UVDS_ASSERT_IMPLY(a_reload_consumes, fire && time_base_next != time_base,
                     (pending || item.measure_request) && !pending_next,
                     "time base reloaded without consuming request")

endmodule

/* sv/uv_duty_cycle_sampler.sv */
// UV sensor duty-cycle sampler.
// Items enter on the s_axis channel: tuser is the kind (0 tick, 1 minute
// maximum read), tdata carries the seconds clock, the sleep and UI flags,
// the measure request and the raw reading. Each item yields exactly one
// transaction on the m_axis channel with the sensor command, the phase
// after the item, the current index, the running and UI maxima and the
// value returned by a minute read (zero for ticks).
// The accepting edge loads the input register, and the result register
// is loaded from the core once the output can advance.
// Throughput is one item per cycle while the output is not stalled.
// The user must write the two periods on the cfg port only while no item
// is in flight; the block itself does not enforce this.
// Reset (synchronous) empties both registers, returns the phase to idle,
// clears time base, request and maxima and restores the default periods.
// When the receiver holds m_axis_tready low the result stays put, one more
// item may wait in the input register, and s_axis_tready then drops.
module uv_duty_cycle_sampler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] now_seconds, [32] asleep, [33] ui_idle, [34] viewing_uv,
  // [35] measure_request, [51:36] raw_uv, [55:52] zero
  input  logic [55:0]                  s_axis_tdata,
  // [0] kind
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] sensor_command, [3:2] phase_now, [11:4] index_now, [19:12] max_now,
  // [27:20] max_view_now, [35:28] minute_max, [39:36] zero
  output logic [39:0]                  m_axis_tdata,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [uvds_pkg::PeriodW-1:0] cfg_data
);
  import uvds_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res_next;
  logic    advance;
  logic    fire;
  item_t   s_item;

  assign s_item.kind            = s_axis_tuser;
  assign s_item.now_seconds     = s_axis_tdata[31:0];
  assign s_item.asleep          = s_axis_tdata[32];
  assign s_item.ui_idle         = s_axis_tdata[33];
  assign s_item.viewing_uv      = s_axis_tdata[34];
  assign s_item.measure_request = s_axis_tdata[35];
  assign s_item.raw_uv          = s_axis_tdata[51:36];

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_item;
    end
  end

  uvds_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.minute_max, out_res.max_view_now, out_res.max_now,
                          out_res.index_now, out_res.phase_now, out_res.sensor_command};

  `include "uv_duty_cycle_sampler_assert.svh"

  `UVDS_ASSERT_IMPLY(a_configure_to_ready,
                     out_valid && out_res.sensor_command == CMD_CONFIGURE,
                     out_res.phase_now == PH_READY, "configure without ready phase")
  `UVDS_ASSERT_IMPLY(a_disable_to_off,
                     out_valid && out_res.sensor_command == CMD_DISABLE,
                     out_res.phase_now == PH_OFF, "disable without off phase")
  `UVDS_ASSERT_IMPLY(a_no_accept_when_full, in_valid && !advance, !s_axis_tready,
                     "input taken while stage blocked")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import uvds_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseItems    = 80;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [31:0] now_seconds, [32] asleep, [33] ui_idle, [34] viewing_uv,
  // [35] measure_request, [51:36] raw_uv, [55:52] zero
  logic [55:0]         s_axis_tdata;
  // [0] kind
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [1:0] sensor_command, [3:2] phase_now, [11:4] index_now, [19:12] max_now,
  // [27:20] max_view_now, [35:28] minute_max, [39:36] zero
  logic [39:0]         m_axis_tdata;
  logic                cfg_we;
  logic                cfg_index;
  logic [PeriodW-1:0]  cfg_data;

  // Shadow copy of the sampler state and its two period registers.
  logic [PeriodW-1:0]  fg_period         = FgPeriodReset;
  logic [PeriodW-1:0]  bg_period         = BgPeriodReset;
  logic [1:0]          sampler_phase     = PH_IDLE;
  logic [TimeW-1:0]    sampler_time_base = '0;
  logic                sampler_request   = 1'b0;
  logic [IndexW-1:0]   sampler_index     = '0;
  logic [IndexW-1:0]   sampler_max       = '0;
  logic [IndexW-1:0]   sampler_view_max  = '0;

  result_t             reports_due[$];
  stim_row_t           directed_rows[$];
  int unsigned         err_count   = 0;
  bit                  steady_flow = 1'b0;
  logic [TimeW-1:0]    wall_seconds = 32'd300;
  bit                  ready_on    = 1'b0;
  int unsigned         ready_left  = 0;

  uv_duty_cycle_sampler u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one item to the shadow state and returns the report it causes.
  function automatic result_t step_sampler(input item_t it);
    result_t         rep;
    logic [TimeW-1:0] diff;
    int unsigned     quotient;
    rep = '0;
    rep.sensor_command = CMD_NONE;
    if (it.kind == KIND_MINUTE) begin
      rep.minute_max = sampler_max;
      sampler_max = sampler_index;
    end else begin
      if (it.measure_request) begin
        sampler_request = 1'b1;
      end
      if (it.asleep) begin
        sampler_phase = PH_IDLE;
      end else begin
        case (sampler_phase)
          PH_IDLE: begin
            sampler_phase = PH_OFF;
          end
          PH_ON: begin
            rep.sensor_command = CMD_CONFIGURE;
            sampler_phase = PH_READY;
          end
          PH_READY: begin
            quotient = (int'(it.raw_uv) * 2) / 7;
            sampler_index = (quotient > 255) ? 8'd255 : quotient[IndexW-1:0];
            if (sampler_max < sampler_index) begin
              sampler_max = sampler_index;
            end
            if (it.ui_idle) begin
              sampler_view_max = sampler_index;
            end else if (sampler_index > sampler_view_max) begin
              sampler_view_max = sampler_max;
            end
            rep.sensor_command = CMD_DISABLE;
            sampler_phase = PH_OFF;
          end
          default: begin
            diff = it.now_seconds - sampler_time_base;
            if (!it.ui_idle && it.viewing_uv) begin
              if (diff > {16'd0, fg_period}) begin
                sampler_phase = PH_ON;
              end
            end else if (diff > {16'd0, bg_period} && sampler_request) begin
              sampler_request = 1'b0;
              sampler_time_base = it.now_seconds;
              sampler_phase = PH_ON;
            end
          end
        endcase
      end
    end
    rep.phase_now    = sampler_phase;
    rep.index_now    = sampler_index;
    rep.max_now      = sampler_max;
    rep.max_view_now = sampler_view_max;
    return rep;
  endfunction

  function automatic item_t make_item(input logic kind, input logic [TimeW-1:0] now,
                                      input logic asleep, input logic ui_idle,
                                      input logic viewing, input logic request,
                                      input logic [RawW-1:0] raw);
    item_t it;
    it.kind            = kind;
    it.now_seconds     = now;
    it.asleep          = asleep;
    it.ui_idle         = ui_idle;
    it.viewing_uv      = viewing;
    it.measure_request = request;
    it.raw_uv          = raw;
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit typed, input result_t want);
    stim_row_t row;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Back to back in steady flow; else mostly, with short or rare long gaps.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(input item_t it, input int unsigned gap, input bit typed,
                           input result_t typed_want);
    result_t predicted;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'd0, it.raw_uv, it.measure_request, it.viewing_uv, it.ui_idle,
                      it.asleep, it.now_seconds};
    do @(posedge clk); while (!s_axis_tready);
    predicted = step_sampler(it);
    reports_due.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_periods(input logic [PeriodW-1:0] fg, input logic [PeriodW-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fg_period = fg;
    bg_period = bg;
  endtask

  task automatic run_random_phase(input logic [PeriodW-1:0] fg, input logic [PeriodW-1:0] bg,
                                  input bit steady);
    item_t it;
    drain_reports();
    write_periods(fg, bg);
    steady_flow = steady;
    for (int n = 0; n < PhaseItems; n++) begin
      // The seconds clock mostly creeps forward so that periods expire now and then.
      if ($urandom_range(0, 19) == 0) begin
        wall_seconds = $urandom();
      end else begin
        wall_seconds = wall_seconds + $urandom_range(0, 4);
      end
      it.kind            = ($urandom_range(0, 9) == 0) ? KIND_MINUTE : KIND_TICK;
      it.now_seconds     = wall_seconds;
      it.asleep          = ($urandom_range(0, 11) == 0);
      it.ui_idle         = 1'($urandom_range(0, 1));
      it.viewing_uv      = 1'($urandom_range(0, 1));
      it.measure_request = ($urandom_range(0, 9) < 3);
      case ($urandom_range(0, 4))
        0: it.raw_uv = 16'($urandom());
        1: it.raw_uv = 16'($urandom_range(0, 895));
        2: it.raw_uv = 16'($urandom_range(890, 900));
        3: it.raw_uv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: it.raw_uv = 16'($urandom_range(0, 4000));
      endcase
      push_item(it, pick_gap(), 1'b0, '0);
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Receiver: short ready bursts broken by stalls, mostly brief and a few long.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_on = ~ready_on;
      if (ready_on) begin
        ready_left = $urandom_range(1, 12);
      end else if ($urandom_range(0, 9) == 0) begin
        ready_left = $urandom_range(15, 50);
      end else begin
        ready_left = $urandom_range(1, 3);
      end
    end
    ready_left--;
    m_axis_tready <= ready_on || steady_flow;
  end

  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        $error("unexpected result transaction: tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("sensor_command", 8'(want.sensor_command), 8'(m_axis_tdata[1:0]));
        check_field("phase_now", 8'(want.phase_now), 8'(m_axis_tdata[3:2]));
        check_field("index_now", want.index_now, m_axis_tdata[11:4]);
        check_field("max_now", want.max_now, m_axis_tdata[19:12]);
        check_field("max_view_now", want.max_view_now, m_axis_tdata[27:20]);
        check_field("minute_max", want.minute_max, m_axis_tdata[35:28]);
        check_field("pad", 8'd0, 8'(m_axis_tdata[39:36]));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_TICK;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FOREGROUND;
    cfg_data      = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed walk at the reset periods (foreground 1, background 100).
    add_row(make_item(KIND_MINUTE, 32'd0, 0, 0, 0, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_IDLE, 8'd0, 8'd0, 8'd0, 8'd0});
    add_row(make_item(KIND_TICK, 32'd0, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd0, 8'd0, 8'd0, 8'd0});
    // The foreground start needs the difference strictly above the period.
    add_row(make_item(KIND_TICK, 32'd1, 0, 0, 1, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd0, 8'd0, 8'd0, 8'd0});
    add_row(make_item(KIND_TICK, 32'd2, 0, 0, 1, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_ON, 8'd0, 8'd0, 8'd0, 8'd0});
    add_row(make_item(KIND_TICK, 32'd3, 0, 0, 1, 0, 16'd0), 1,
            result_t'{CMD_CONFIGURE, PH_READY, 8'd0, 8'd0, 8'd0, 8'd0});
    // Full-scale reading saturates the index.
    add_row(make_item(KIND_TICK, 32'd4, 0, 1, 0, 0, 16'hFFFF), 1,
            result_t'{CMD_DISABLE, PH_OFF, 8'd255, 8'd255, 8'd255, 8'd0});
    // A minute read ignores sleep and the other tick fields.
    add_row(make_item(KIND_MINUTE, 32'hFFFF_FFFF, 1, 1, 1, 1, 16'hFFFF), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd255, 8'd255, 8'd255, 8'd255});
    add_row(make_item(KIND_TICK, 32'd100, 0, 1, 0, 1, 16'd0), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd255, 8'd255, 8'd255, 8'd0});
    add_row(make_item(KIND_TICK, 32'd101, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_ON, 8'd255, 8'd255, 8'd255, 8'd0});
    // Sleep drops to idle but still latches the request.
    add_row(make_item(KIND_TICK, 32'd102, 1, 1, 0, 1, 16'd0), 1,
            result_t'{CMD_NONE, PH_IDLE, 8'd255, 8'd255, 8'd255, 8'd0});
    add_row(make_item(KIND_TICK, 32'd103, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd255, 8'd255, 8'd255, 8'd0});
    add_row(make_item(KIND_TICK, 32'hFFFF_FFFF, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_ON, 8'd255, 8'd255, 8'd255, 8'd0});
    add_row(make_item(KIND_TICK, 32'd0, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_CONFIGURE, PH_READY, 8'd255, 8'd255, 8'd255, 8'd0});
    add_row(make_item(KIND_TICK, 32'd1, 0, 1, 0, 0, 16'd0), 1,
            result_t'{CMD_DISABLE, PH_OFF, 8'd0, 8'd255, 8'd0, 8'd0});
    add_row(make_item(KIND_MINUTE, 32'd2, 1, 0, 1, 1, 16'hFFFF), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd0, 8'd0, 8'd0, 8'd255});
    // Wrapped difference exceeds the period, but no request is pending, and
    // viewing does not count while the UI is idle.
    add_row(make_item(KIND_TICK, 32'd100, 0, 1, 1, 0, 16'd0), 1,
            result_t'{CMD_NONE, PH_OFF, 8'd0, 8'd0, 8'd0, 8'd0});
    add_row(make_item(KIND_TICK, 32'd200, 0, 0, 1, 0, 16'd0), 0, '0);
    add_row(make_item(KIND_TICK, 32'd201, 0, 0, 1, 0, 16'd0), 0, '0);
    add_row(make_item(KIND_TICK, 32'd202, 0, 0, 1, 0, 16'd700), 0, '0);
    add_row(make_item(KIND_TICK, 32'd203, 0, 0, 1, 0, 16'd0), 0, '0);
    add_row(make_item(KIND_TICK, 32'd204, 0, 0, 1, 0, 16'd0), 0, '0);
    add_row(make_item(KIND_TICK, 32'd205, 0, 1, 0, 0, 16'd35), 0, '0);
    add_row(make_item(KIND_TICK, 32'd206, 0, 0, 1, 0, 16'd0), 0, '0);
    add_row(make_item(KIND_TICK, 32'd207, 0, 0, 1, 0, 16'd0), 0, '0);
    // The UI maximum jumps to the running maximum, not to the new index.
    add_row(make_item(KIND_TICK, 32'd208, 0, 0, 1, 0, 16'd350), 0, '0);

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].it, pick_gap(), directed_rows[i].typed,
                directed_rows[i].want);
    end

    run_random_phase(16'd0, 16'd0, 1'b0);
    run_random_phase(16'hFFFF, 16'hFFFF, 1'b0);
    run_random_phase(16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)), 1'b1);
    run_random_phase(FgPeriodReset, BgPeriodReset, 1'b0);
    run_random_phase(16'($urandom()), 16'($urandom_range(0, 200)), 1'b0);

    drain_reports();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
